[rtl/quoted_string_array_parser_macros.svh]
`ifndef QUOTED_STRING_ARRAY_PARSER_MACROS_SVH
`define QUOTED_STRING_ARRAY_PARSER_MACROS_SVH

// Assert that a condition implies another in the same cycle.
`define QSAP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: same-cycle check failed");

// Assert that a condition implies another in the next cycle.
`define QSAP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/qsap_pkg.sv]
`default_nettype none

package qsap_pkg;

  localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA         = 8'h2C;
  localparam logic [7:0] CH_QUOTE         = 8'h22;
  localparam logic [7:0] CH_BACKSLASH     = 8'h5C;
  localparam logic [7:0] CH_N             = 8'h6E;
  localparam logic [7:0] CH_R             = 8'h72;
  localparam logic [7:0] CH_T             = 8'h74;
  localparam logic [7:0] CH_SPACE         = 8'h20;
  localparam logic [7:0] CH_TAB           = 8'h09;
  localparam logic [7:0] CH_LF            = 8'h0A;
  localparam logic [7:0] CH_CR            = 8'h0D;

  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_BRACKET       = 3'd1;
  localparam logic [2:0] ERR_EXP_STRING    = 3'd2;
  localparam logic [2:0] ERR_EXP_COMMA     = 3'd3;
  localparam logic [2:0] ERR_UNTERM_ESCAPE = 3'd4;
  localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd5;
  localparam logic [2:0] ERR_UNTERM_STRING = 3'd6;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] decoded_char;
    logic       string_end;
    logic       text_done;
    logic [2:0] error_code;
  } result_t;

endpackage

`default_nettype wire

[rtl/qsap_parser.sv]
`default_nettype none

module qsap_parser import qsap_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  output result_t         res,
  output logic            has_result
);

  typedef enum logic [2:0] {
    PH_OPEN, PH_FIRST, PH_STR, PH_ESC, PH_AFTER, PH_NEXT, PH_TAIL, PH_ERR
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  phase_t ph;
  logic   blank;

  always_comb begin
    blank = (text_byte == CH_SPACE) || (text_byte inside {[CH_TAB:CH_CR]});
    ph = phase;
    res = '0;
    case (phase)
      PH_OPEN: begin
        if (text_byte == CH_OPEN_BRACKET) ph = PH_FIRST;
        else if (!blank) res.error_code = ERR_BRACKET;
      end
      PH_FIRST: begin
        if (text_byte == CH_CLOSE_BRACKET) ph = PH_TAIL;
        else if (text_byte == CH_QUOTE) ph = PH_STR;
        else if (!blank) res.error_code = ERR_EXP_STRING;
      end
      PH_STR: begin
        if (text_byte == CH_QUOTE) begin
          res.string_end = 1'b1;
          ph = PH_AFTER;
        end else if (text_byte == CH_BACKSLASH) begin
          ph = PH_ESC;
        end else begin
          res.char_valid = 1'b1;
          res.decoded_char = text_byte;
        end
      end
      PH_ESC: begin
        ph = PH_STR;
        res.char_valid = 1'b1;
        case (text_byte)
          CH_BACKSLASH, CH_QUOTE: res.decoded_char = text_byte;
          CH_N: res.decoded_char = CH_LF;
          CH_R: res.decoded_char = CH_CR;
          CH_T: res.decoded_char = CH_TAB;
          default: begin
            res.char_valid = 1'b0;
            res.error_code = ERR_BAD_ESCAPE;
          end
        endcase
      end
      PH_AFTER: begin
        if (text_byte == CH_CLOSE_BRACKET) ph = PH_TAIL;
        else if (text_byte == CH_COMMA) ph = PH_NEXT;
        else if (!blank) res.error_code = ERR_EXP_COMMA;
      end
      PH_NEXT: begin
        if (text_byte == CH_QUOTE) ph = PH_STR;
        else if (!blank) res.error_code = ERR_EXP_STRING;
      end
      PH_TAIL: begin
        if (!blank) res.error_code = ERR_BRACKET;
      end
      default: ;
    endcase

    if (res.error_code != ERR_NONE) begin
      ph = PH_ERR;
    end else if (final_byte) begin
      case (ph)
        PH_OPEN:  res.error_code = ERR_BRACKET;
        PH_FIRST: res.error_code = ERR_EXP_STRING;
        PH_STR:   res.error_code = ERR_UNTERM_STRING;
        PH_ESC:   res.error_code = ERR_UNTERM_ESCAPE;
        PH_AFTER: res.error_code = ERR_EXP_COMMA;
        PH_NEXT:  res.error_code = ERR_EXP_STRING;
        default:  res.text_done = 1'b1;
      endcase
    end

    if (phase == PH_ERR) res = '0;

    has_result = res.char_valid || res.string_end || res.text_done ||
                 (res.error_code != ERR_NONE);
    phase_next = final_byte ? PH_OPEN : ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPEN;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

[rtl/qsap_out_stage.sv]
`default_nettype none

module qsap_out_stage import qsap_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  result_t skid;
  logic    skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data   <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= load_data;
        out_valid <= load;
      end
    end else if (load) begin
      skid       <= load_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/quoted_string_array_parser.sv]
// Channel   Handshake                  Payload
// text      text_valid / text_stall    text_byte, final_byte
// result    result_valid / result_stall char_valid, decoded_char, string_end,
//                                      text_done, error_code
// One byte per cycle while text_stall is low; a result is registered in the output stage once its byte is accepted.
// The byte is decoded in one registered pass; the phase register is the only loop.
// A two-entry output stage absorbs one stalled result; text_stall rises only
// when both entries are held.
// Reset is synchronous on rst and returns the parser to expecting '['.
`default_nettype none

module quoted_string_array_parser import qsap_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            char_valid,
  output logic [7:0]      decoded_char,
  output logic            string_end,
  output logic            text_done,
  output logic [2:0]      error_code
);

  logic    accept;
  logic    has_result;
  logic    full;
  result_t res;
  result_t out_data;

  assign text_stall = full;
  assign accept     = text_valid && !full;

  qsap_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .res        (res),
    .has_result (has_result)
  );

  qsap_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && has_result),
    .load_data (res),
    .full      (full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (out_data)
  );

  assign char_valid   = out_data.char_valid;
  assign decoded_char = out_data.decoded_char;
  assign string_end   = out_data.string_end;
  assign text_done    = out_data.text_done;
  assign error_code   = out_data.error_code;

endmodule

`default_nettype wire

[rtl/qsap_checker.sv]
`default_nettype none
`include "quoted_string_array_parser_macros.svh"

module qsap_checker import qsap_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic       char_valid,
  input wire logic [7:0] decoded_char,
  input wire logic       string_end,
  input wire logic       text_done,
  input wire logic [2:0] error_code
);

  logic any_field;
  logic done_alone;

  assign any_field  = char_valid || string_end || text_done || (error_code != ERR_NONE);
  assign done_alone = (error_code == ERR_NONE) && !char_valid && !string_end;

  `QSAP_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid)
  `QSAP_ASSERT_NEXT(a_hold_char, result_valid && result_stall, $stable(decoded_char))
  `QSAP_ASSERT_NOW(a_nonempty, result_valid, any_field)
  `QSAP_ASSERT_NOW(a_done_clean, result_valid && text_done, done_alone)

endmodule

bind quoted_string_array_parser qsap_checker u_qsap_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .char_valid   (char_valid),
  .decoded_char (decoded_char),
  .string_end   (string_end),
  .text_done    (text_done),
  .error_code   (error_code)
);

`default_nettype wire

[bench/tb_quoted_string_array_parser.sv]
module tb_quoted_string_array_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import qsap_pkg::*;

  localparam int RANDOM_BYTES = 1350;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    AWAIT_OPEN,
    AWAIT_FIRST,
    IN_STRING,
    IN_ESCAPE,
    AFTER_STRING,
    AFTER_COMMA,
    AFTER_CLOSE,
    SKIP_TO_END
  } list_phase_t;

  typedef struct {
    logic [7:0] text;
    logic       last;
    bit         typed;
    bit         present;
    result_t    res;
  } byte_entry_t;

  logic       clk;
  logic       rst          = 1'b1;
  logic       text_valid   = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte    = 8'h00;
  logic       final_byte   = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       char_valid;
  logic [7:0] decoded_char;
  logic       string_end;
  logic       text_done;
  logic [2:0] error_code;

  byte_entry_t byte_queue[$];
  byte_entry_t inflight;
  result_t     awaited[$];
  logic [7:0]  draft[$];
  list_phase_t list_phase = AWAIT_OPEN;
  int          bytes_taken = 0;
  int          total_bytes = 0;
  int          failures = 0;
  int          stuck_cycles = 0;
  wire         calm = (bytes_taken >= 500) && (bytes_taken < 800);

  quoted_string_array_parser dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_valid   (char_valid),
    .decoded_char (decoded_char),
    .string_end   (string_end),
    .text_done    (text_done),
    .error_code   (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_gap(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit parse_step(input logic [7:0] c, input logic fin, output result_t r);
    list_phase_t nxt;
    r = '0;
    nxt = list_phase;
    if (list_phase == SKIP_TO_END) begin
      if (fin) list_phase = AWAIT_OPEN;
      return 1'b0;
    end
    case (list_phase)
      AWAIT_OPEN: begin
        if (c == CH_OPEN_BRACKET) nxt = AWAIT_FIRST;
        else if (!is_gap(c)) r.error_code = ERR_BRACKET;
      end
      AWAIT_FIRST: begin
        if (c == CH_CLOSE_BRACKET) nxt = AFTER_CLOSE;
        else if (c == CH_QUOTE) nxt = IN_STRING;
        else if (!is_gap(c)) r.error_code = ERR_EXP_STRING;
      end
      IN_STRING: begin
        if (c == CH_QUOTE) begin
          r.string_end = 1'b1;
          nxt = AFTER_STRING;
        end else if (c == CH_BACKSLASH) begin
          nxt = IN_ESCAPE;
        end else begin
          r.char_valid = 1'b1;
          r.decoded_char = c;
        end
      end
      IN_ESCAPE: begin
        nxt = IN_STRING;
        r.char_valid = 1'b1;
        case (c)
          CH_BACKSLASH, CH_QUOTE: r.decoded_char = c;
          CH_N: r.decoded_char = CH_LF;
          CH_R: r.decoded_char = CH_CR;
          CH_T: r.decoded_char = CH_TAB;
          default: begin
            r.char_valid = 1'b0;
            r.error_code = ERR_BAD_ESCAPE;
          end
        endcase
      end
      AFTER_STRING: begin
        if (c == CH_CLOSE_BRACKET) nxt = AFTER_CLOSE;
        else if (c == CH_COMMA) nxt = AFTER_COMMA;
        else if (!is_gap(c)) r.error_code = ERR_EXP_COMMA;
      end
      AFTER_COMMA: begin
        if (c == CH_QUOTE) nxt = IN_STRING;
        else if (!is_gap(c)) r.error_code = ERR_EXP_STRING;
      end
      default: begin
        if (!is_gap(c)) r.error_code = ERR_BRACKET;
      end
    endcase
    if (r.error_code != ERR_NONE) begin
      nxt = SKIP_TO_END;
    end else if (fin) begin
      case (nxt)
        AWAIT_OPEN:               r.error_code = ERR_BRACKET;
        AWAIT_FIRST, AFTER_COMMA: r.error_code = ERR_EXP_STRING;
        IN_STRING:                r.error_code = ERR_UNTERM_STRING;
        IN_ESCAPE:                r.error_code = ERR_UNTERM_ESCAPE;
        AFTER_STRING:             r.error_code = ERR_EXP_COMMA;
        default:                  r.text_done = 1'b1;
      endcase
    end
    list_phase = fin ? AWAIT_OPEN : nxt;
    return r != '0;
  endfunction

  task automatic add_item(input logic [7:0] b, input logic fin);
    byte_entry_t e;
    e.text = b;
    e.last = fin;
    e.typed = 1'b0;
    e.present = 1'b0;
    e.res = '0;
    byte_queue = {byte_queue, e};
  endtask

  task automatic add_checked(input logic [7:0] b, input logic fin, input bit present,
                             input logic cv, input logic [7:0] ch, input logic se,
                             input logic done, input logic [2:0] err);
    byte_entry_t e;
    e.text = b;
    e.last = fin;
    e.typed = 1'b1;
    e.present = present;
    e.res = {cv, ch, se, done, err};
    byte_queue = {byte_queue, e};
  endtask

  function automatic logic [7:0] gap_byte();
    int unsigned v;
    v = $urandom_range(5);
    return (v == 5) ? CH_SPACE : CH_TAB + v[7:0];
  endfunction

  function automatic logic [7:0] escape_byte(input bit allow_bad);
    case ($urandom_range(allow_bad ? 5 : 4))
      0: return CH_BACKSLASH;
      1: return CH_QUOTE;
      2: return CH_N;
      3: return CH_R;
      4: return CH_T;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(7))
      0: return CH_OPEN_BRACKET;
      1: return CH_CLOSE_BRACKET;
      2: return CH_COMMA;
      3: return CH_QUOTE;
      4: return CH_BACKSLASH;
      5: return gap_byte();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_gaps();
    repeat ($urandom_range(2)) draft = {draft, gap_byte()};
  endtask

  task automatic build_list(input bit allow_bad);
    int unsigned n_str;
    int unsigned n_chr;
    logic [7:0]  c;
    add_gaps();
    draft = {draft, CH_OPEN_BRACKET};
    add_gaps();
    n_str = $urandom_range(3);
    for (int k = 0; k < n_str; k++) begin
      if (k > 0) begin
        draft = {draft, CH_COMMA};
        add_gaps();
      end
      draft = {draft, CH_QUOTE};
      n_chr = $urandom_range(6);
      for (int j = 0; j < n_chr; j++) begin
        if ($urandom_range(5) == 0) begin
          draft = {draft, CH_BACKSLASH};
          draft = {draft, escape_byte(allow_bad)};
        end else begin
          do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
          draft = {draft, c};
        end
      end
      draft = {draft, CH_QUOTE};
      add_gaps();
    end
    draft = {draft, CH_CLOSE_BRACKET};
    add_gaps();
  endtask

  task automatic queue_text();
    int unsigned mode;
    int unsigned cut;
    draft.delete();
    mode = $urandom_range(99);
    if (mode < 92) build_list(mode >= 80);
    else repeat ($urandom_range(1, 8)) draft = {draft, pick_noise()};
    if (mode >= 70 && mode < 80) begin
      cut = $urandom_range(1, draft.size());
      draft = draft[0:cut-1];
    end
    if (mode >= 80 && mode < 92) draft[$urandom_range(draft.size() - 1)] = pick_noise();
    foreach (draft[i]) add_item(draft[i], i == draft.size() - 1);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : send_side
    result_t want;
    bit      got_one;
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        got_one = parse_step(inflight.text, inflight.last, want);
        if (inflight.typed) begin
          if (inflight.present) awaited = {awaited, inflight.res};
        end else if (got_one) begin
          awaited = {awaited, want};
        end
        bytes_taken++;
      end
      // advance only when the current transaction is gone
      if (!text_valid || !text_stall) begin
        if (byte_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          inflight = byte_queue.pop_front();
          text_valid <= 1'b1;
          text_byte <= inflight.text;
          final_byte <= inflight.last;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_side
    result_t seen;
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        seen = {char_valid, decoded_char, string_end, text_done, error_code};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, seen);
          failures++;
        end else begin
          want = awaited.pop_front();
          check_field("char_valid", 8'(want.char_valid), 8'(seen.char_valid));
          check_field("decoded_char", want.decoded_char, seen.decoded_char);
          check_field("string_end", 8'(want.string_end), 8'(seen.string_end));
          check_field("text_done", 8'(want.text_done), 8'(seen.text_done));
          check_field("error_code", 8'(want.error_code), 8'(seen.error_code));
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    add_checked(CH_OPEN_BRACKET, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
    add_item(CH_QUOTE, 1'b0);
    add_checked(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, ERR_NONE);
    add_checked(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, ERR_NONE);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_QUOTE, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_N, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_R, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_item(CH_T, 1'b0);
    add_item(CH_QUOTE, 1'b0);
    add_checked(CH_CLOSE_BRACKET, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE);
    add_checked(CH_SPACE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BRACKET);
    add_item(CH_OPEN_BRACKET, 1'b0);
    add_item(CH_QUOTE, 1'b0);
    add_checked(8'h61, 1'b1, 1'b1, 1'b1, 8'h61, 1'b0, 1'b0, ERR_UNTERM_STRING);
    add_item(CH_OPEN_BRACKET, 1'b0);
    add_item(CH_QUOTE, 1'b0);
    add_item(CH_BACKSLASH, 1'b0);
    add_checked(8'h71, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BAD_ESCAPE);
    add_checked(CH_COMMA, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
    add_checked(CH_CLOSE_BRACKET, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BRACKET);
    total_bytes = byte_queue.size() + RANDOM_BYTES;
    while (byte_queue.size() < total_bytes) queue_text();
    total_bytes = byte_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes || awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/qsap_pkg.sv
rtl/qsap_parser.sv
rtl/qsap_out_stage.sv
rtl/quoted_string_array_parser.sv
rtl/qsap_checker.sv
bench/tb_quoted_string_array_parser.sv
